FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files of the luma PSNR meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/lpm_pkg.sv
// Types and constants shared by the luma PSNR meter modules.
package lpm_pkg;

    // Frame geometry
    localparam int MAX_DIM  = 2048;
    localparam int DIM_W    = 12;
    localparam int EFF_W    = $clog2(MAX_DIM) + 1;
    localparam int CNT_W    = 2 * $clog2(MAX_DIM) + 1;

    // Sample and result widths
    localparam int PIX_W    = 8;
    localparam int SQ_W     = 2 * PIX_W;
    localparam int ACC_W    = 38;
    localparam int PSNR_W   = 16;

    // Log2 unit: operand wide enough for the error sum and for 65025 * N
    localparam int PEAK_W    = 2 * PIX_W + 2 * $clog2(MAX_DIM);
    localparam int LOGX_W    = (ACC_W > PEAK_W) ? ACC_W : PEAK_W;
    localparam int POS_W     = $clog2(LOGX_W);
    localparam int FRAC_W    = 8;
    localparam int LOG_W     = POS_W + FRAC_W;
    localparam int MANT_W    = 31;
    localparam int NORM_STEPS = POS_W;
    localparam int STEP_W    = 3;
    localparam int NORM_TOP  = 1 << (POS_W - 1);

    // Fixed-point constants: 255^2 and 10*log10(2) in Q.8
    localparam int PEAK_SQ      = 65025;
    localparam int DB_PER_LOG2  = 771;
    localparam int DB_W         = 10;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd1080;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACC,
        ST_START,
        ST_NORM,
        ST_MANT,
        ST_SQR,
        ST_NEXT,
        ST_FINAL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic              take_pixel;
        logic              load_peak;
        logic              load_sse;
        logic              norm_step;
        logic [STEP_W-1:0] norm_sel;
        logic              load_mant;
        logic              sq_step;
        logic              finish;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;
        logic sse_zero;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/luma_psnr_meter_unit.sv
// Top level of the luma PSNR meter: controller, datapath and assertions.
//
// Usage: reference and test luma samples arrive as one transaction per pixel on
// the s_axis channel (tdata bits 7:0 reference, 15:8 test). The block sums the
// squared differences; when the pixel count reaches frame_width * frame_height
// (dimensions of 0 count as 1, above 2048 as 2048) one result leaves on m_axis.
// Frame dimensions are written through the cfg channel (index 0 width, index 1
// height) while no frame is in progress; other indexes are ignored.
// Throughput: one pixel per cycle inside a frame. After the last pixel the
// block drops s_axis_tready while the shared log2 unit evaluates log2(65025*N)
// and log2(sse), 6 normalize and 8 squaring steps each, one 31x31 multiplier
// step per cycle; a zero error sum skips both. The result sits in an output
// register; the next frame is taken while it waits, and a stalled receiver
// only holds the block at the end of that next frame. Reset (aresetn low,
// synchronous) clears the accumulator, pixel count and output valid, and sets
// the dimensions to 1920 x 1080.
`include "assert_macros.svh"

module luma_psnr_meter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpm_pkg::DIM_W-1:0]     cfg_data,
    // pixel pairs
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // ref_pixel, test_pixel
    // frame results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [55:0]                   m_axis_tdata,  // psnr_db_q8, error_sum, zero pad
    output logic                          m_axis_tuser   // perfect_match
);

    lpm_pkg::ctl_cmd_t   ctl_cmd;
    lpm_pkg::dp_status_t dp_status;

    logic [lpm_pkg::PSNR_W-1:0] psnr_db_q8;
    logic [lpm_pkg::ACC_W-1:0]  error_sum;

    assign cfg_ready = 1'b1;

    lpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    lpm_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ref_pixel     (s_axis_tdata[7:0]),
        .test_pixel    (s_axis_tdata[15:8]),
        .cmd           (ctl_cmd),
        .status        (dp_status),
        .m_tready      (m_axis_tready),
        .m_tvalid      (m_axis_tvalid),
        .psnr_db_q8    (psnr_db_q8),
        .error_sum     (error_sum),
        .perfect_match (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, error_sum, psnr_db_q8};

    // Assertions
    `ASSERT_IMPL(a_finish_out_free, aclk, aresetn, ctl_cmd.finish, (!m_axis_tvalid || m_axis_tready), "result loaded over a pending transaction")
    `ASSERT_IMPL(a_no_pixel_in_log, aclk, aresetn, (ctl_cmd.sq_step || ctl_cmd.norm_step), !s_axis_tready, "pixel taken while log unit busy")
    `ASSERT_NEXT(a_finish_valid, aclk, aresetn, ctl_cmd.finish, m_axis_tvalid, "finished result not presented")
    `ASSERT_IMPL(a_perfect_psnr, aclk, aresetn, (m_axis_tvalid && m_axis_tuser), ((m_axis_tdata[15:0] == 16'hFFFF) && (m_axis_tdata[53:16] == 38'd0)), "perfect match with nonzero error")

endmodule

FILE: sv/lpm_datapath.sv
// Datapath: config registers, error accumulator, shared log2 unit, output register.
module lpm_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [lpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpm_pkg::DIM_W-1:0]   cfg_data,
    input  logic [lpm_pkg::PIX_W-1:0]   ref_pixel,
    input  logic [lpm_pkg::PIX_W-1:0]   test_pixel,
    input  lpm_pkg::ctl_cmd_t           cmd,
    output lpm_pkg::dp_status_t         status,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [lpm_pkg::PSNR_W-1:0]  psnr_db_q8,
    output logic [lpm_pkg::ACC_W-1:0]   error_sum,
    output logic                        perfect_match
);

    // Configuration registers
    logic [lpm_pkg::DIM_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lpm_pkg::WIDTH_RESET;
            height_reg <= lpm_pkg::HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lpm_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                lpm_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions and frame size
    logic [lpm_pkg::EFF_W-1:0]   eff_w, eff_h;
    logic [2*lpm_pkg::EFF_W-1:0] n_full;
    logic [lpm_pkg::CNT_W-1:0]   frame_n;

    always_comb begin
        if (width_reg == '0)
            eff_w = lpm_pkg::EFF_W'(1);
        else if (32'(width_reg) > lpm_pkg::MAX_DIM)
            eff_w = lpm_pkg::EFF_W'(lpm_pkg::MAX_DIM);
        else
            eff_w = lpm_pkg::EFF_W'(width_reg);
        if (height_reg == '0)
            eff_h = lpm_pkg::EFF_W'(1);
        else if (32'(height_reg) > lpm_pkg::MAX_DIM)
            eff_h = lpm_pkg::EFF_W'(lpm_pkg::MAX_DIM);
        else
            eff_h = lpm_pkg::EFF_W'(height_reg);
        n_full  = eff_w * eff_h;
        frame_n = n_full[lpm_pkg::CNT_W-1:0];
    end

    // Squared error and saturating accumulate
    logic [lpm_pkg::PIX_W-1:0] diff;
    logic [lpm_pkg::SQ_W-1:0]  sq;
    logic [lpm_pkg::ACC_W:0]   acc_sum;
    logic [lpm_pkg::ACC_W-1:0] acc_sat;
    logic [lpm_pkg::CNT_W-1:0] cnt_inc;
    logic                      frame_end;

    logic [lpm_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [lpm_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        diff    = (ref_pixel > test_pixel) ? ref_pixel - test_pixel : test_pixel - ref_pixel;
        sq      = diff * diff;
        acc_sum = {1'b0, acc_reg} + (lpm_pkg::ACC_W + 1)'(sq);
        acc_sat = acc_sum[lpm_pkg::ACC_W] ? '1 : acc_sum[lpm_pkg::ACC_W-1:0];
        cnt_inc = cnt_reg + lpm_pkg::CNT_W'(1);
        frame_end = (cnt_inc >= frame_n);
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.take_pixel) begin
            if (frame_end) begin
                acc_next = '0;
                cnt_next = '0;
            end else begin
                acc_next = acc_sat;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Frame capture: error sum and frame size at the last pixel
    logic [lpm_pkg::ACC_W-1:0] sse_reg;
    logic [lpm_pkg::CNT_W-1:0] n_cap_reg;
    logic                      sse_zero;

    always_ff @(posedge aclk) begin
        if (cmd.take_pixel && frame_end) begin
            sse_reg   <= acc_sat;
            n_cap_reg <= frame_n;
        end
    end

    assign sse_zero = (sse_reg == '0);

    // Log2 unit: normalize by binary search, then square the mantissa
    logic [lpm_pkg::LOGX_W-1:0]         x_reg;
    logic [lpm_pkg::POS_W-1:0]          p_reg;
    logic [lpm_pkg::MANT_W-1:0]         m_reg;
    logic [lpm_pkg::FRAC_W-1:0]         frac_reg;
    logic [lpm_pkg::LOG_W-1:0]          lp_reg;
    logic [lpm_pkg::LOGX_W-1:0]         peak_prod;
    logic [lpm_pkg::POS_W:0]            norm_k;
    logic [lpm_pkg::LOGX_W-1:0]         x_shl;
    logic                               no_loss;
    logic [2*lpm_pkg::MANT_W-1:0]       sq_full;
    logic [lpm_pkg::MANT_W:0]           sq_shr;

    always_comb begin
        peak_prod = lpm_pkg::LOGX_W'(lpm_pkg::PEAK_SQ) * lpm_pkg::LOGX_W'(n_cap_reg);
        norm_k    = (lpm_pkg::POS_W + 1)'(lpm_pkg::NORM_TOP) >> cmd.norm_sel;
        x_shl     = x_reg << norm_k;
        no_loss   = ((x_shl >> norm_k) == x_reg);
        sq_full   = m_reg * m_reg;
        sq_shr    = sq_full[2*lpm_pkg::MANT_W-1:lpm_pkg::MANT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_peak) begin
            x_reg <= peak_prod;
            p_reg <= lpm_pkg::POS_W'(lpm_pkg::LOGX_W - 1);
        end else if (cmd.load_sse) begin
            x_reg  <= lpm_pkg::LOGX_W'(sse_reg);
            p_reg  <= lpm_pkg::POS_W'(lpm_pkg::LOGX_W - 1);
            lp_reg <= {p_reg, frac_reg};
        end else if (cmd.norm_step && no_loss) begin
            x_reg <= x_shl;
            p_reg <= p_reg - norm_k[lpm_pkg::POS_W-1:0];
        end
        if (cmd.load_mant) begin
            m_reg    <= x_reg[lpm_pkg::LOGX_W-1 -: lpm_pkg::MANT_W];
            frac_reg <= '0;
        end else if (cmd.sq_step) begin
            // A square at or above 2.0 yields a one bit and is halved
            if (sq_shr[lpm_pkg::MANT_W]) begin
                m_reg    <= sq_shr[lpm_pkg::MANT_W:1];
                frac_reg <= {frac_reg[lpm_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                m_reg    <= sq_shr[lpm_pkg::MANT_W-1:0];
                frac_reg <= {frac_reg[lpm_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    // PSNR = (L(peak*N) - L(sse)) * 771 >> 8
    logic [lpm_pkg::LOG_W-1:0]            le;
    logic [lpm_pkg::LOG_W-1:0]            log_diff;
    logic [lpm_pkg::LOG_W+lpm_pkg::DB_W-1:0] db_prod;
    logic [lpm_pkg::PSNR_W-1:0]           psnr_calc;

    always_comb begin
        le       = {p_reg, frac_reg};
        log_diff = (lp_reg > le) ? lp_reg - le : '0;
        db_prod  = log_diff * lpm_pkg::DB_W'(lpm_pkg::DB_PER_LOG2);
        if (db_prod[lpm_pkg::LOG_W+lpm_pkg::DB_W-1:lpm_pkg::FRAC_W] > {lpm_pkg::PSNR_W{1'b1}})
            psnr_calc = '1;
        else
            psnr_calc = lpm_pkg::PSNR_W'(db_prod >> lpm_pkg::FRAC_W);
    end

    // Output register
    logic                       out_valid_reg;
    logic                       out_free;
    logic [lpm_pkg::PSNR_W-1:0] psnr_reg;
    logic [lpm_pkg::ACC_W-1:0]  sum_reg;
    logic                       match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            sum_reg   <= sse_reg;
            match_reg <= sse_zero;
            psnr_reg  <= sse_zero ? '1 : psnr_calc;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign psnr_db_q8    = psnr_reg;
    assign error_sum     = sum_reg;
    assign perfect_match = match_reg;
    assign out_free      = !out_valid_reg || m_tready;

    // Status to the controller, in field order frame_end, sse_zero, out_free
    assign status = {frame_end, sse_zero, out_free};

endmodule

FILE: sv/lpm_ctrl.sv
// Controller: frame accumulation and sequencing of the two log2 evaluations.
module lpm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lpm_pkg::dp_status_t status,
    output lpm_pkg::ctl_cmd_t   cmd
);

    lpm_pkg::state_t state_reg, state_next;
    logic [lpm_pkg::STEP_W-1:0] step_reg, step_next;
    logic second_reg, second_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lpm_pkg::ST_ACC;
            step_reg   <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            second_reg <= second_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        second_next = second_reg;
        cmd         = '0;
        cmd.norm_sel = step_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            lpm_pkg::ST_ACC: begin
                s_tready = 1'b1;
                cmd.take_pixel = s_tvalid;
                if (s_tvalid && status.frame_end)
                    state_next = lpm_pkg::ST_START;
            end
            lpm_pkg::ST_START: begin
                step_next   = '0;
                second_next = 1'b0;
                if (status.sse_zero) begin
                    state_next = lpm_pkg::ST_FINAL;
                end else begin
                    cmd.load_peak = 1'b1;
                    state_next    = lpm_pkg::ST_NORM;
                end
            end
            lpm_pkg::ST_NORM: begin
                cmd.norm_step = 1'b1;
                if (step_reg == lpm_pkg::STEP_W'(lpm_pkg::NORM_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = lpm_pkg::ST_MANT;
                end else begin
                    step_next = step_reg + lpm_pkg::STEP_W'(1);
                end
            end
            lpm_pkg::ST_MANT: begin
                cmd.load_mant = 1'b1;
                state_next    = lpm_pkg::ST_SQR;
            end
            lpm_pkg::ST_SQR: begin
                cmd.sq_step = 1'b1;
                if (step_reg == lpm_pkg::STEP_W'(lpm_pkg::FRAC_W - 1)) begin
                    step_next  = '0;
                    state_next = second_reg ? lpm_pkg::ST_FINAL : lpm_pkg::ST_NEXT;
                end else begin
                    step_next = step_reg + lpm_pkg::STEP_W'(1);
                end
            end
            lpm_pkg::ST_NEXT: begin
                // Keep the peak log and start on the error sum
                cmd.load_sse = 1'b1;
                second_next  = 1'b1;
                state_next   = lpm_pkg::ST_NORM;
            end
            lpm_pkg::ST_FINAL: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = lpm_pkg::ST_ACC;
                end
            end
            default: state_next = lpm_pkg::ST_ACC;
        endcase
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the luma PSNR meter: pixel-pair stream in, frame results out.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RUN_LIMIT    = 600000;
    localparam int unsigned SETTLE_CYC   = 40;
    localparam int unsigned HOLD_CYC     = 400;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned OVERSIZE_PIX = 400;
    localparam logic [63:0] SSE_CEIL     = (64'd1 << lpm_pkg::ACC_W) - 64'd1;
    // indexes the block has no register for
    localparam logic [lpm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [lpm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // pixel content patterns
    typedef enum int {PAT_RANDOM, PAT_SAME, PAT_CLOSE, PAT_RAILS} pix_pat_t;

    typedef struct packed {
        logic [lpm_pkg::PSNR_W-1:0] psnr;
        logic [lpm_pkg::ACC_W-1:0]  sse;
        logic                       perfect;
    } frame_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lpm_pkg::DIM_W-1:0]     cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata = '0;   // ref_pixel, test_pixel
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [55:0]                   m_axis_tdata;        // psnr_db_q8, error_sum, zero pad
    logic                          m_axis_tuser;        // perfect_match

    luma_psnr_meter_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow state of the meter
    logic [lpm_pkg::DIM_W-1:0] shadow_width  = lpm_pkg::WIDTH_RESET;
    logic [lpm_pkg::DIM_W-1:0] shadow_height = lpm_pkg::HEIGHT_RESET;
    logic [63:0]      sse_running   = '0;
    logic [63:0]      pixels_seen   = '0;

    logic [15:0]      pixel_q[$];
    frame_result_t    pending_frames[$];

    int unsigned cycle_cnt = 0;
    int unsigned fail_cnt  = 0;
    int unsigned gap_left  = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_trig = 0;
    int unsigned hold_seen = 0;
    int unsigned items_sent = 0;
    logic        calm = 1'b0;
    logic        px_fire = 1'b0;
    logic        cfg_fire = 1'b0;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_cnt++;
    endtask

    function automatic logic [63:0] clamp_dim(logic [lpm_pkg::DIM_W-1:0] v);
        if (v == 0) return 64'd1;
        if (v > lpm_pkg::MAX_DIM) return 64'(lpm_pkg::MAX_DIM);
        return 64'(v);
    endfunction

    // Q.8 log2: leading-one position, then 8 bits by squaring the Q1.30 mantissa
    function automatic int unsigned log2_q8(logic [63:0] x);
        int unsigned pos;
        int unsigned frac;
        logic [63:0] mant;
        pos  = 0;
        frac = 0;
        while (pos < 63 && (x >> (pos + 1)) != 0) pos++;
        if (pos >= 30) mant = x >> (pos - 30);
        else mant = x << (30 - pos);
        for (int i = 0; i < 8; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return pos * 256 + frac;
    endfunction

    // Accumulate one pixel pair and queue the frame result when the frame closes
    task automatic absorb_pixel(logic [7:0] ref_px, logic [7:0] test_px);
        logic [7:0]    delta;
        logic [63:0]   frame_px;
        logic [63:0]   db;
        int unsigned   log_peak;
        int unsigned   log_err;
        frame_result_t res;
        delta = (ref_px > test_px) ? ref_px - test_px : test_px - ref_px;
        sse_running = sse_running + 64'(delta) * 64'(delta);
        if (sse_running > SSE_CEIL) sse_running = SSE_CEIL;
        pixels_seen = pixels_seen + 1;
        frame_px = clamp_dim(shadow_width) * clamp_dim(shadow_height);
        if (pixels_seen >= frame_px) begin
            res.sse = sse_running[lpm_pkg::ACC_W-1:0];
            if (sse_running == 0) begin
                res.psnr    = '1;
                res.perfect = 1'b1;
            end else begin
                log_peak = log2_q8(64'(lpm_pkg::PEAK_SQ) * frame_px);
                log_err  = log2_q8(sse_running);
                db = (log_peak > log_err) ? 64'(log_peak - log_err) : 64'd0;
                db = (db * lpm_pkg::DB_PER_LOG2) >> 8;
                res.psnr    = (db > 64'hFFFF) ? 16'hFFFF : db[15:0];
                res.perfect = 1'b0;
            end
            pending_frames.push_back(res);
            sse_running = '0;
            pixels_seen = '0;
        end
    endtask

    // Transactions seen at the rising edge: config, pixels, predictor
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
        px_fire  <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                lpm_pkg::CFG_FRAME_WIDTH:  shadow_width  = cfg_data;
                lpm_pkg::CFG_FRAME_HEIGHT: shadow_height = cfg_data;
                default: ;
            endcase
        end
        if (aresetn && s_axis_tvalid && s_axis_tready)
            absorb_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8]);
    end

    // Result monitor
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                report("frame result with none pending", m_axis_tdata[15:0], 0);
            end else begin
                want = pending_frames.pop_front();
                if (m_axis_tdata[15:0] !== want.psnr)
                    report("psnr_db_q8", m_axis_tdata[15:0], want.psnr);
                if (m_axis_tdata[53:16] !== want.sse)
                    report("error_sum", m_axis_tdata[53:16], want.sse);
                if (m_axis_tuser !== want.perfect)
                    report("perfect_match", m_axis_tuser, want.perfect);
            end
        end
    end

    // Pixel driver with random gaps
    always @(negedge aclk) begin
        if (!s_axis_tvalid || px_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_axis_tdata  <= pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0) gap_left <= $urandom_range(1, 13);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_seen != hold_trig) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYC;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver with random stalls
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 13);
        end
    end

    task automatic write_reg(logic [lpm_pkg::CFG_IDX_W-1:0] idx,
                             logic [lpm_pkg::DIM_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [lpm_pkg::DIM_W-1:0] w, logic [lpm_pkg::DIM_W-1:0] h);
        write_reg(lpm_pkg::CFG_FRAME_WIDTH, w);
        write_reg(lpm_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    task automatic push_pair(logic [7:0] ref_px, logic [7:0] test_px);
        pixel_q.push_back({test_px, ref_px});
        items_sent++;
    endtask

    task automatic push_pattern(pix_pat_t pat, int unsigned count);
        logic [7:0] r;
        logic [7:0] t;
        repeat (count) begin
            r = 8'($urandom);
            case (pat)
                PAT_SAME:  t = r;
                PAT_CLOSE: t = r + 8'($urandom_range(0, 3));
                PAT_RAILS: begin
                    r = {8{1'($urandom_range(0, 1))}};
                    t = {8{1'($urandom_range(0, 1))}};
                end
                default:   t = 8'($urandom);
            endcase
            push_pair(r, t);
        end
    endtask

    // All pixels taken, all results out, then let the log unit drain
    task automatic settle();
        while (pixel_q.size() != 0 || s_axis_tvalid || pending_frames.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    function automatic logic [lpm_pkg::DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return lpm_pkg::DIM_W'($urandom_range(7, 24));
        return lpm_pkg::DIM_W'($urandom_range(1, 6));
    endfunction

    // Stimulus sequence
    initial begin
        int unsigned               frame_px;
        int unsigned               frames;
        int unsigned               extra;
        logic [lpm_pkg::DIM_W-1:0] w;
        logic [lpm_pkg::DIM_W-1:0] h;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // single-pixel frames: zero error, full-scale error both ways, alternating bit patterns
        set_frame(12'd1, 12'd1);
        push_pair(8'd0, 8'd0);
        push_pair(8'd255, 8'd0);
        push_pair(8'd0, 8'd255);
        push_pair(8'd255, 8'd255);
        push_pair(8'hAA, 8'h55);
        push_pair(8'h55, 8'hAA);
        settle();

        // zero dimensions count as one
        set_frame(12'd0, 12'd0);
        push_pair(8'd1, 8'd0);
        push_pair(8'd128, 8'd128);
        settle();

        // writes to unused indexes leave the 2x3 frame alone
        set_frame(12'd2, 12'd3);
        write_reg(CFG_SPARE_LO, 12'hFFF);
        write_reg(CFG_SPARE_HI, 12'd0);
        push_pattern(PAT_RANDOM, 6);
        settle();

        // shrink the frame mid-way: the next pixel closes it
        set_frame(12'd4, 12'd4);
        push_pattern(PAT_RANDOM, 10);
        settle();
        set_frame(12'd2, 12'd2);
        push_pair(8'd7, 8'd200);
        settle();

        // receiver holds off while tiny frames pile up
        set_frame(12'd1, 12'd2);
        hold_trig = hold_trig + 1;
        push_pattern(PAT_RANDOM, 60);
        settle();

        // random geometry and content until the item budget is used,
        // sometimes a partial frame left open
        while (items_sent < RANDOM_ITEMS) begin
            w = pick_dim();
            h = pick_dim();
            set_frame(w, h);
            frame_px = int'(clamp_dim(w) * clamp_dim(h));
            frames = (frame_px > 64) ? 1 : $urandom_range(1, 4);
            extra = (frame_px > 1 && $urandom_range(0, 4) == 0) ?
                    $urandom_range(1, frame_px - 1) : 0;
            push_pattern(pix_pat_t'($urandom_range(0, 3)), frames * frame_px + extra);
            settle();
        end

        // oversize width and zero height give 2048 x 1: no result part way,
        // then a smaller frame closes it at the next pixel
        set_frame(12'hFFF, 12'd0);
        repeat (OVERSIZE_PIX) begin
            if ($urandom_range(0, 9) != 0) push_pair(8'd255, 8'd0);
            else push_pattern(PAT_RANDOM, 1);
        end
        settle();
        set_frame(12'd16, 12'd16);
        push_pair(8'd3, 8'd250);
        settle();

        // closing stretch with no idling
        calm = 1'b1;
        set_frame(12'd3, 12'd3);
        push_pattern(PAT_RANDOM, 90);
        settle();

        if (pending_frames.size() != 0)
            report("frame results never delivered", 0, pending_frames.size());
        if (fail_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
